>>> rtl/core/rc6_pkg.sv
// ----------------------------------------------------------------------------
// RC6 package
// Shared payload types and cipher constants for the RC6 block cipher.
// ----------------------------------------------------------------------------
package rc6_pkg;

    localparam logic [31:0] P32 = 32'hB7E15163;
    localparam logic [31:0] Q32 = 32'h9E3779B9;

    localparam logic [2:0] REG_KEY_LEN = 3'd0;
    localparam logic [2:0] REG_KEY_0   = 3'd1;
    localparam logic [2:0] REG_KEY_1   = 3'd2;
    localparam logic [2:0] REG_KEY_2   = 3'd3;
    localparam logic [2:0] REG_KEY_3   = 3'd4;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] in_a;
        logic [31:0] in_b;
        logic [31:0] in_c;
        logic [31:0] in_d;
    } rc6_in_t;

    typedef struct packed {
        logic [31:0] out_a;
        logic [31:0] out_b;
        logic [31:0] out_c;
        logic [31:0] out_d;
    } rc6_out_t;

endpackage

>>> rtl/core/rc6_block_cipher.sv
// ----------------------------------------------------------------------------
// RC6 block cipher
// RC6-32/ROUNDS encrypt/decrypt with an on-demand key schedule.
// Every round key comes from the single-port round-key RAM with a registered
//   read, and each round steps through S_RND0, S_RND1, S_POST and S_OUT. The
//   first block after a write to the key length or key registers first runs the
//   key schedule: S_FILL writes the 2*ROUNDS+4 magic-constant words, then
//   3*(2*ROUNDS+4) mixing steps run (c is at most 8), each via S_MIX_RD/A/B.
// Throughput: one block at a time; the next transaction is accepted once the
//   result has been taken. Reset: idle, keys not expanded, key length 16, key
//   bytes zero; the round-key RAM is not cleared.
// ----------------------------------------------------------------------------
module rc6_block_cipher #(
    parameter int ROUNDS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rc6_pkg::rc6_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rc6_pkg::rc6_out_t   out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import rc6_pkg::*;

    localparam int NKEYS = 2 * ROUNDS + 4;
    localparam int KW    = $clog2(NKEYS);
    localparam int MW    = $clog2(3 * NKEYS + 1) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_MIX_RD, S_MIX_A, S_MIX_B,
        S_PRE_RD, S_PRE0, S_PRE1, S_RND_RD0, S_RND0, S_RND1, S_POST, S_OUT
    } state_t;

    // Configuration registers
    logic [5:0]  key_len_reg;
    logic [63:0] key_reg [4];
    logic        keys_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg    <= 6'd16;
            key_reg[0]     <= '0;
            key_reg[1]     <= '0;
            key_reg[2]     <= '0;
            key_reg[3]     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_LEN: key_len_reg <= cfg_data[5:0];
                REG_KEY_0:   key_reg[0]  <= cfg_data;
                REG_KEY_1:   key_reg[1]  <= cfg_data;
                REG_KEY_2:   key_reg[2]  <= cfg_data;
                REG_KEY_3:   key_reg[3]  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective key length and key word count
    logic [5:0] len_eff;
    logic [3:0] c_words;
    always_comb
    begin
        len_eff = key_len_reg;
        if (len_eff == 6'd0)
            len_eff = 6'd1;
        if (len_eff > 6'd32)
            len_eff = 6'd32;
        c_words = 4'(((len_eff - 6'd1) >> 2) + 6'd1);
    end

    // Masked key bytes as eight words
    logic [255:0] key_all;
    logic [255:0] key_masked;
    always_comb
    begin
        key_all = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
        for (int n = 0; n < 32; n++)
            key_masked[8*n +: 8] = (n < int'(len_eff)) ? key_all[8*n +: 8] : 8'h00;
    end

    // Round-key RAM, one port, registered read
    logic [31:0] rk_mem [NKEYS];
    logic        rk_we;
    logic [KW-1:0] rk_addr;
    logic [31:0] rk_wdata;
    logic [31:0] rk_rdata;

    always_ff @(posedge clk)
    begin
        if (rk_we)
            rk_mem[rk_addr] <= rk_wdata;
        rk_rdata <= rk_mem[rk_addr];
    end

    state_t       state_reg;
    logic [KW-1:0] si_reg;
    logic [2:0]   li_reg;
    logic [MW-1:0] mix_cnt_reg;
    logic [31:0]  fill_reg;
    logic [31:0]  ka_reg, kb_reg;
    logic [31:0]  lw_reg [8];
    logic         op_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [KW-1:0] rnd_reg;
    logic         out_valid_reg;
    logic [31:0]  qt_reg, qu_reg;

    function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} >> n;
        return t[31:0];
    endfunction

    function automatic logic [31:0] quad5(input logic [31:0] x);
        logic [31:0] f;
        f = x * {x[30:0], 1'b1};
        return rol(f, 5'd5);
    endfunction

    // Key mixing datapath
    logic [31:0] mix_a, mix_b, mix_ab;
    assign mix_a  = rol(rk_rdata + ka_reg + kb_reg, 5'd3);
    assign mix_ab = ka_reg + kb_reg;
    assign mix_b  = rol(lw_reg[li_reg] + mix_ab, mix_ab[4:0]);

    localparam logic [MW-1:0] MIX_FIX = MW'(3 * NKEYS);
    logic [MW-1:0] mix_total;
    assign mix_total = MIX_FIX;

    logic [KW-1:0] si_inc;
    assign si_inc = (si_reg == KW'(NKEYS - 1)) ? '0 : si_reg + 1'b1;

    // Round-key address and write
    always_comb
    begin
        rk_we    = 1'b0;
        rk_wdata = fill_reg;
        rk_addr  = si_reg;
        case (state_reg)
            S_FILL: rk_we = 1'b1;
            S_MIX_A:
            begin
                rk_we    = 1'b1;
                rk_wdata = mix_a;
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg && !cfg_we;
    assign out_valid = out_valid_reg;
    assign out_data  = '{out_a: a_reg, out_b: b_reg, out_c: c_reg, out_d: d_reg};

    logic [31:0] t_q, u_q;
    assign t_q = quad5(b_reg);
    assign u_q = quad5(d_reg);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            keys_ready_reg <= 1'b0;
            si_reg         <= '0;
            li_reg         <= '0;
            mix_cnt_reg    <= '0;
            rnd_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index <= REG_KEY_3)
                keys_ready_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg <= in_data.op;
                        a_reg  <= in_data.in_a;
                        b_reg  <= in_data.in_b;
                        c_reg  <= in_data.in_c;
                        d_reg  <= in_data.in_d;
                        si_reg <= '0;
                        if (keys_ready_reg)
                        begin
                            rnd_reg   <= '0;
                            state_reg <= S_PRE_RD;
                        end
                        else
                        begin
                            fill_reg  <= P32;
                            for (int w = 0; w < 8; w++)
                                lw_reg[w] <= key_masked[32*w +: 32];
                            state_reg <= S_FILL;
                        end
                    end
                end
                // Fill with magic constants
                S_FILL:
                begin
                    fill_reg <= fill_reg + Q32;
                    si_reg   <= si_inc;
                    if (si_reg == KW'(NKEYS - 1))
                    begin
                        ka_reg      <= '0;
                        kb_reg      <= '0;
                        li_reg      <= '0;
                        mix_cnt_reg <= '0;
                        state_reg   <= S_MIX_RD;
                    end
                end
                S_MIX_RD: state_reg <= S_MIX_A;
                // Write back new key word; S_MIX_B then computes the new L word
                S_MIX_A:
                begin
                    ka_reg    <= mix_a;
                    state_reg <= S_MIX_B;
                end
                S_MIX_B:
                begin
                    kb_reg         <= mix_b;
                    lw_reg[li_reg] <= mix_b;
                    si_reg         <= si_inc;
                    li_reg         <= (4'(li_reg) + 4'd1 == c_words) ? '0 : li_reg + 1'b1;
                    mix_cnt_reg    <= mix_cnt_reg + 1'b1;
                    if (mix_cnt_reg + 1'b1 == mix_total)
                    begin
                        keys_ready_reg <= 1'b1;
                        state_reg      <= S_PRE_RD;
                    end
                    else
                        state_reg <= S_MIX_RD;
                end
                // Whitening before rounds
                S_PRE_RD:
                begin
                    si_reg    <= (op_reg == OP_ENCRYPT) ? KW'(0) : KW'(NKEYS - 1);
                    state_reg <= S_PRE0;
                end
                S_PRE0:
                begin
                    si_reg    <= (op_reg == OP_ENCRYPT) ? KW'(1) : KW'(NKEYS - 2);
                    state_reg <= S_PRE1;
                end
                S_PRE1:
                begin
                    if (op_reg == OP_ENCRYPT)
                        b_reg <= b_reg + rk_rdata;
                    else
                        c_reg <= c_reg - rk_rdata;
                    state_reg <= S_RND_RD0;
                    rnd_reg   <= '0;
                end
                S_RND_RD0:
                begin
                    // second input whitening word, or an output whitening word
                    if (rnd_reg == '0)
                    begin
                        if (op_reg == OP_ENCRYPT)
                        begin
                            d_reg  <= d_reg + rk_rdata;
                            si_reg <= KW'(2);
                        end
                        else
                        begin
                            a_reg  <= a_reg - rk_rdata;
                            si_reg <= KW'(NKEYS - 3);
                        end
                        state_reg <= S_RND0;
                    end
                    else if (rnd_reg == KW'(ROUNDS + 1))
                    begin
                        if (op_reg == OP_ENCRYPT)
                            a_reg <= a_reg + rk_rdata;
                        else
                            d_reg <= d_reg - rk_rdata;
                        rnd_reg <= rnd_reg + 1'b1;
                    end
                    else if (rnd_reg == KW'(ROUNDS + 2))
                    begin
                        if (op_reg == OP_ENCRYPT)
                            c_reg <= c_reg + rk_rdata;
                        else
                            b_reg <= b_reg - rk_rdata;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_RND0;
                end
                // Request second key of round, compute quadratics
                S_RND0:
                begin
                    if (op_reg == OP_ENCRYPT)
                    begin
                        qt_reg <= t_q;
                        qu_reg <= u_q;
                        si_reg <= si_reg + 1'b1;
                    end
                    else
                    begin
                        // undo the rotation first: a<-d,b<-a,c<-b,d<-c
                        qt_reg <= quad5(a_reg);
                        qu_reg <= quad5(c_reg);
                        si_reg <= si_reg - 1'b1;
                    end
                    state_reg <= S_RND1;
                end
                S_RND1:
                begin
                    if (op_reg == OP_ENCRYPT)
                    begin
                        // rk_rdata = S[2i]; odd key read next cycle
                        a_reg <= rol(a_reg ^ qt_reg, qu_reg[4:0]) + rk_rdata;
                    end
                    else
                    begin
                        // rk_rdata = S[2i+1]; rotate words back
                        a_reg <= d_reg;
                        b_reg <= a_reg;
                        c_reg <= ror(b_reg - rk_rdata, qt_reg[4:0]) ^ qu_reg;
                        d_reg <= c_reg;
                    end
                    state_reg <= S_POST;
                end
                S_POST:
                begin
                    if (op_reg == OP_ENCRYPT)
                    begin
                        // rk_rdata = S[2i+1]; rotate words
                        a_reg  <= b_reg;
                        b_reg  <= rol(c_reg ^ qu_reg, qt_reg[4:0]) + rk_rdata;
                        c_reg  <= d_reg;
                        d_reg  <= a_reg;
                        si_reg <= (rnd_reg == KW'(ROUNDS - 1)) ? KW'(NKEYS - 2) : si_reg + 1'b1;
                    end
                    else
                    begin
                        // rk_rdata = S[2i]
                        a_reg  <= ror(a_reg - rk_rdata, qu_reg[4:0]) ^ qt_reg;
                        si_reg <= (rnd_reg == KW'(ROUNDS - 1)) ? KW'(1) : si_reg - 1'b1;
                    end
                    rnd_reg   <= rnd_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // wait for the registered read of the next key
                    if (rnd_reg == KW'(ROUNDS))
                    begin
                        si_reg    <= (op_reg == OP_ENCRYPT) ? KW'(NKEYS - 1) : KW'(0);
                        rnd_reg   <= rnd_reg + 1'b1;
                        state_reg <= S_RND_RD0;
                    end
                    else
                        state_reg <= S_RND0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Assertions
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE && !out_valid_reg)
        else $error("accept while busy");
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index <= REG_KEY_3 && state_reg == S_IDLE |=> !keys_ready_reg)
        else $error("config write did not clear key ready");

endmodule
